[hw/rtl/ihd_pkg.sv]
// Shared types, codes and the hex digit decoder of the record decoder.
package ihd_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       line_end;
    } t_in_word;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [31:0] byte_address;
        logic [2:0]  status;
        logic [2:0]  accepted_type;
        logic        section_break;
        logic [31:0] record_start;
    } t_out_word;

    // Per-line summary handed from the line tracker to the record checker.
    typedef struct packed {
        logic        emit;
        logic [7:0]  data_byte;
        logic [7:0]  data_offset;
        logic [7:0]  count;
        logic [7:0]  rec_type;
        logic [15:0] offset;
        logic [15:0] extension;
        logic [7:0]  sum;
        logic [1:0]  flags;
        logic [9:0]  nbytes;
        logic [11:0] length;
    } t_line_info;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_nibble;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HEADER   = 3'd1;
    localparam logic [2:0] ST_SIZE     = 3'd2;
    localparam logic [2:0] ST_CHAR     = 3'd3;
    localparam logic [2:0] ST_CHECKSUM = 3'd4;
    localparam logic [2:0] ST_TYPE     = 3'd5;
    localparam logic [2:0] ST_FORMAT   = 3'd6;

    localparam logic [7:0] REC_DATA    = 8'd0;
    localparam logic [7:0] REC_EXT_SEG = 8'd2;
    localparam logic [7:0] REC_EXT_LIN = 8'd4;
    localparam logic [7:0] REC_LAST    = 8'd5;

    localparam logic [9:0] IDX_COUNT  = 10'd0;
    localparam logic [9:0] IDX_OFF_HI = 10'd1;
    localparam logic [9:0] IDX_OFF_LO = 10'd2;
    localparam logic [9:0] IDX_TYPE   = 10'd3;
    localparam logic [9:0] IDX_EXT_HI = 10'd4;
    localparam logic [9:0] IDX_EXT_LO = 10'd5;
    localparam logic [9:0] IDX_DATA   = 10'd4;
    localparam logic [9:0] HDR_BYTES  = 10'd5;
    localparam logic [9:0] IDX_MAX    = 10'd1023;

    localparam logic [10:0] CHAR_MAX = 11'd2047;
    localparam logic [7:0]  COLON    = 8'h3A;
    localparam logic [7:0]  EXT_FORMAT_COUNT = 8'd2;

    function automatic t_nibble hex_decode(input logic [7:0] c);
        t_nibble r;
        r = '{ok: 1'b1, value: 4'd0};
        case (c) inside
            [8'h30:8'h39]: r.value = 4'(c - 8'h30);
            [8'h41:8'h46]: r.value = 4'(c - 8'h37);
            [8'h61:8'h66]: r.value = 4'(c - 8'h57);
            default:       r.ok    = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/intel_hex_record_decoder.sv]
// Intel HEX record decoder top level: input register, line tracker, record checker, result register.
// Each accepted word passes the input register, then the result register, which drives o_out_valid.
// Throughput: one character word per cycle; the input register advances whenever the
//   result register is empty or is being taken, so stalls cost only the cycles held.
// Reset (i_rst_n low, synchronous) clears the line state, address prefix, section
//   tracking, the checksum-skip register and both valid flags; no clearing pass.
module intel_hex_record_decoder #(
    parameter int MAX_LINE_CHARS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ihd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ihd_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data
);
    import ihd_pkg::*;

    logic       r_ignore_checksum;
    logic       r_in_valid;
    t_in_word   r_in;
    logic       r_out_valid;
    t_out_word  r_out;

    logic       advance;
    t_line_info info;
    logic       res_valid;
    t_out_word  res_word;

    // Advance the held word when the result register is free or draining this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Hold the checksum-skip bit; the user must write it only while the block is idle; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_checksum <= 1'b0;
        end else if (i_cfg_we) begin
            r_ignore_checksum <= i_cfg_data;
        end
    end

    // Input register: take a new word whenever it is empty or the held one moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_word;
        end
    end

    ihd_line u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_word    (r_in),
        .o_info    (info)
    );

    ihd_record #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_record (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (advance),
        .i_line_end        (r_in.line_end),
        .i_ignore_checksum (r_ignore_checksum),
        .i_info            (info),
        .o_valid           (res_valid),
        .o_word            (res_word)
    );

    // Result register: load on advance, drop valid once taken with nothing behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_line_end_gives_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.line_end) |=> (o_out_valid && o_out_word.kind == KIND_STATUS))
        else $error("line end word did not produce a status word");

    a_data_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.kind == KIND_DATA)
        |-> (o_out_word.status == ST_OK && o_out_word.accepted_type == 3'd0))
        else $error("data word carries status fields");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while both registers are full and stalled");

endmodule

[hw/rtl/ihd_line.sv]
// Per-line character tracker: digit pairing, header fields, checksum sum, error flags.
module ihd_line (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  ihd_pkg::t_in_word   i_word,
    output ihd_pkg::t_line_info o_info
);
    import ihd_pkg::*;

    logic [10:0] r_char_count, n_char_count;
    logic [3:0]  r_high_nibble, n_high_nibble;
    logic [9:0]  r_byte_index, n_byte_index;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_offset, n_offset;
    logic [15:0] r_ext, n_ext;
    logic [1:0]  r_flags, n_flags;

    t_nibble     nib;
    logic [3:0]  nib_val;
    logic        decoding;
    logic        pair_done;
    logic [7:0]  pair_byte;
    logic [9:0]  data_pos;

    always_comb begin
        nib       = hex_decode(i_word.character);
        decoding  = (r_char_count != 11'd0) && (r_char_count != CHAR_MAX);
        nib_val   = nib.ok ? nib.value : 4'd0;
        pair_done = decoding && !r_char_count[0];
        pair_byte = {r_high_nibble, nib_val};
        data_pos  = r_byte_index - IDX_DATA;

        n_flags = r_flags;
        if (r_char_count == 11'd0 && i_word.character != COLON) begin
            n_flags[0] = 1'b1;
        end
        if (decoding && !nib.ok) begin
            n_flags[1] = 1'b1;
        end

        n_high_nibble = (decoding && r_char_count[0]) ? nib_val : r_high_nibble;
        n_sum         = pair_done ? r_sum + pair_byte : r_sum;
        n_count       = r_count;
        n_type        = r_type;
        n_offset      = r_offset;
        n_ext         = r_ext;
        if (pair_done) begin
            unique case (r_byte_index)
                IDX_COUNT:  n_count        = pair_byte;
                IDX_OFF_HI: n_offset[15:8] = pair_byte;
                IDX_OFF_LO: n_offset[7:0]  = pair_byte;
                IDX_TYPE:   n_type         = pair_byte;
                IDX_EXT_HI: n_ext[15:8]    = pair_byte;
                IDX_EXT_LO: n_ext[7:0]     = pair_byte;
                default: ;
            endcase
        end
        n_byte_index = (pair_done && r_byte_index != IDX_MAX) ? r_byte_index + 10'd1
                                                              : r_byte_index;
        n_char_count = (r_char_count != CHAR_MAX) ? r_char_count + 11'd1 : r_char_count;

        o_info.emit        = pair_done && !i_word.line_end && (n_flags == 2'b00)
                             && (n_type == REC_DATA) && (r_byte_index >= IDX_DATA)
                             && (data_pos < {2'b00, n_count});
        o_info.data_byte   = pair_byte;
        o_info.data_offset = data_pos[7:0];
        o_info.count       = n_count;
        o_info.rec_type    = n_type;
        o_info.offset      = n_offset;
        o_info.extension   = n_ext;
        o_info.sum         = n_sum;
        o_info.flags       = n_flags;
        o_info.nbytes      = n_byte_index;
        o_info.length      = {1'b0, r_char_count} + 12'd1;
    end

    // Clear the whole line state on the line-end word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count  <= '0;
            r_high_nibble <= '0;
            r_byte_index  <= '0;
            r_sum         <= '0;
            r_count       <= '0;
            r_type        <= '0;
            r_offset      <= '0;
            r_ext         <= '0;
            r_flags       <= '0;
        end else if (i_advance) begin
            if (i_word.line_end) begin
                r_char_count  <= '0;
                r_high_nibble <= '0;
                r_byte_index  <= '0;
                r_sum         <= '0;
                r_count       <= '0;
                r_type        <= '0;
                r_offset      <= '0;
                r_ext         <= '0;
                r_flags       <= '0;
            end else begin
                r_char_count  <= n_char_count;
                r_high_nibble <= n_high_nibble;
                r_byte_index  <= n_byte_index;
                r_sum         <= n_sum;
                r_count       <= n_count;
                r_type        <= n_type;
                r_offset      <= n_offset;
                r_ext         <= n_ext;
                r_flags       <= n_flags;
            end
        end
    end

endmodule

[hw/rtl/ihd_record.sv]
// Record checker: status at line end, address prefix and section tracking, result build.
module ihd_record #(
    parameter int MAX_LINE_CHARS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic                i_line_end,
    input  logic                i_ignore_checksum,
    input  ihd_pkg::t_line_info i_info,
    output logic                o_valid,
    output ihd_pkg::t_out_word  o_word
);
    import ihd_pkg::*;

    localparam logic [11:0] MaxLen = 12'(MAX_LINE_CHARS);

    logic [31:0] r_prefix, n_prefix;
    logic        r_open, n_open;
    logic [31:0] r_next_addr, n_next_addr;

    logic [2:0]  status;
    logic [31:0] base;
    logic        accept_data;
    logic        fire;

    always_comb begin
        if (i_info.flags[0]) begin
            status = ST_HEADER;
        end else if (!i_info.length[0] || i_info.length > MaxLen) begin
            status = ST_SIZE;
        end else if (i_info.flags[1]) begin
            status = ST_CHAR;
        end else if (!i_ignore_checksum && i_info.sum != 8'd0) begin
            status = ST_CHECKSUM;
        end else if (i_info.nbytes < HDR_BYTES
                     || {2'b00, i_info.count} != i_info.nbytes - HDR_BYTES) begin
            status = ST_SIZE;
        end else if (i_info.rec_type > REC_LAST) begin
            status = ST_TYPE;
        end else if ((i_info.rec_type == REC_EXT_SEG || i_info.rec_type == REC_EXT_LIN)
                     && (i_info.count != EXT_FORMAT_COUNT || i_info.offset != 16'd0)) begin
            status = ST_FORMAT;
        end else begin
            status = ST_OK;
        end

        base        = r_prefix | {16'd0, i_info.offset};
        accept_data = (status == ST_OK) && (i_info.rec_type == REC_DATA);
        fire        = i_advance && i_line_end && (status == ST_OK);

        n_prefix    = r_prefix;
        n_open      = r_open;
        n_next_addr = r_next_addr;
        if (fire) begin
            if (i_info.rec_type == REC_DATA) begin
                n_open      = 1'b1;
                n_next_addr = base + {24'd0, i_info.count};
            end else if (i_info.rec_type == REC_EXT_SEG) begin
                n_prefix = {12'd0, i_info.extension, 4'd0};
            end else if (i_info.rec_type == REC_EXT_LIN) begin
                n_prefix = {i_info.extension, 16'd0};
            end
        end

        o_valid = i_line_end || i_info.emit;
        o_word  = '0;
        if (i_line_end) begin
            o_word.kind   = KIND_STATUS;
            o_word.status = status;
            if (status == ST_OK) begin
                o_word.accepted_type = i_info.rec_type[2:0];
            end
            if (accept_data) begin
                o_word.record_start  = base;
                o_word.section_break = r_open && (r_next_addr != base);
            end
        end else begin
            o_word.kind         = KIND_DATA;
            o_word.data_byte    = i_info.data_byte;
            o_word.byte_address = base + {24'd0, i_info.data_offset};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix    <= '0;
            r_open      <= 1'b0;
            r_next_addr <= '0;
        end else begin
            r_prefix    <= n_prefix;
            r_open      <= n_open;
            r_next_addr <= n_next_addr;
        end
    end

    a_break_needs_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.section_break) |-> r_open)
        else $error("section break reported with no open section");

    a_prefix_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_prefix) && $stable(r_next_addr))
        else $error("cross-line state changed without an accepted record");

    a_start_only_ok_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.record_start != 32'd0) |-> accept_data && i_line_end)
        else $error("record start given for a record that is not an accepted data record");

endmodule

[bench/intel_hex_record_decoder_tb.sv]
// Self-checking testbench of the Intel HEX record decoder.
module intel_hex_record_decoder_tb;
    import ihd_pkg::*;

    localparam int LINE_LIMIT    = 1024;  // MAX_LINE_CHARS of the instance
    localparam int CNT_SAT       = 2047;  // character counter saturation
    localparam int IDX_SAT       = 1023;  // byte index saturation
    localparam int SETTLE_CYCLES = 6;     // two-stage pipeline plus margin
    localparam int DRAIN_LIMIT   = 20000; // give up on missing words after this
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_CHARS   = 280;   // three random phases of this many characters

    // Record types the package leaves without a name.
    localparam logic [7:0] REC_EOF       = 8'd1;
    localparam logic [7:0] REC_START_SEG = 8'd3;

    // Directed stimulus: one character per row, with a typed-in status where it is obvious.
    typedef struct {
        logic [7:0] ch;
        logic       is_last;
        logic       typed;
        logic [2:0] st;
        logic [2:0] rt;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_word  o_out_word;
    logic       i_cfg_we;
    logic       i_cfg_data;

    // Predictor state: per-line fields and the state kept across lines.
    logic [10:0] char_cnt    = '0;
    logic [3:0]  hi_nib      = '0;
    logic [9:0]  byte_idx    = '0;
    logic [7:0]  line_sum    = '0;
    logic [7:0]  cnt_fld     = '0;
    logic [7:0]  type_fld    = '0;
    logic [15:0] off_fld     = '0;
    logic [15:0] ext_fld     = '0;
    logic [1:0]  err_flags   = '0;
    logic [31:0] addr_prefix = '0;
    logic        sect_open   = 1'b0;
    logic [31:0] next_addr   = '0;
    logic        skip_checksum = 1'b0;

    t_out_word awaited_words[$];
    t_out_word want;

    logic calm = 1'b0;   // high during the stretch with no idling on either side
    int   fail_count = 0;
    int   chars_sent = 0;
    int   lines_sent = 0;
    int   data_checked = 0;
    int   status_checked = 0;
    int   status_seen[8];

    // Short lines for the header, size, character and end-of-file cases,
    // plus the character extremes 8'h00 and 8'hFF.
    t_stim_row directed_rows[19] = '{
        '{8'hFF, 1'b1, 1'b1, ST_HEADER, 3'(REC_DATA)},
        '{8'h00, 1'b1, 1'b1, ST_HEADER, 3'(REC_DATA)},
        '{COLON, 1'b1, 1'b1, ST_SIZE,   3'(REC_DATA)},
        '{COLON, 1'b0, 1'b0, ST_OK,     3'(REC_DATA)},
        '{8'h30, 1'b1, 1'b1, ST_SIZE,   3'(REC_DATA)},
        '{COLON, 1'b0, 1'b0, ST_OK,     3'(REC_DATA)},
        '{8'h47, 1'b0, 1'b0, ST_OK,     3'(REC_DATA)},
        '{8'h67, 1'b1, 1'b1, ST_CHAR,   3'(REC_DATA)},
        '{COLON, 1'b0, 1'b0, ST_OK,     3'(REC_DATA)},
        '{8'h30, 1'b0, 1'b0, ST_OK,     3'(REC_DATA)},
        '{8'h30, 1'b0, 1'b0, ST_OK,     3'(REC_DATA)},
        '{8'h30, 1'b0, 1'b0, ST_OK,     3'(REC_DATA)},
        '{8'h30, 1'b0, 1'b0, ST_OK,     3'(REC_DATA)},
        '{8'h30, 1'b0, 1'b0, ST_OK,     3'(REC_DATA)},
        '{8'h30, 1'b0, 1'b0, ST_OK,     3'(REC_DATA)},
        '{8'h30, 1'b0, 1'b0, ST_OK,     3'(REC_DATA)},
        '{8'h31, 1'b0, 1'b0, ST_OK,     3'(REC_DATA)},
        '{8'h46, 1'b0, 1'b0, ST_OK,     3'(REC_DATA)},
        '{8'h46, 1'b1, 1'b1, ST_OK,     3'(REC_EOF)}
    };

    intel_hex_record_decoder #(
        .MAX_LINE_CHARS(LINE_LIMIT)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Decode one ASCII hex digit: bit 4 says the character is a digit at all.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
        return 5'b0;
    endfunction

    // Encode a nibble as a hex digit; pick upper or lower case letters at random.
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    // Advance the predictor by one character and queue the word it causes, if any.
    function automatic void decode_character(input logic [7:0] c, input logic is_last);
        logic [10:0] pos;
        logic [4:0]  nv;
        logic [7:0]  b;
        logic [2:0]  st;
        int          len;
        t_out_word   w;

        pos = char_cnt;
        if (pos == 0) begin
            if (c != COLON) err_flags[0] = 1'b1;
        end else if (pos < CNT_SAT) begin
            nv = nibble_of(c);
            if (!nv[4]) err_flags[1] = 1'b1;
            if (pos[0]) begin
                hi_nib = nv[3:0];
            end else begin
                b = {hi_nib, nv[3:0]};
                line_sum = line_sum + b;
                case (byte_idx)
                    IDX_COUNT:  cnt_fld        = b;
                    IDX_OFF_HI: off_fld[15:8]  = b;
                    IDX_OFF_LO: off_fld[7:0]   = b;
                    IDX_TYPE:   type_fld       = b;
                    IDX_EXT_HI: ext_fld[15:8]  = b;
                    IDX_EXT_LO: ext_fld[7:0]   = b;
                    default: ;
                endcase
                // Emit a tentative byte only inside the data field of a clean data record.
                if (!is_last && err_flags == 2'b00 && type_fld == REC_DATA &&
                    byte_idx >= IDX_DATA && (byte_idx - IDX_DATA) < {2'b00, cnt_fld}) begin
                    w = '0;
                    w.kind = KIND_DATA;
                    w.data_byte = b;
                    w.byte_address = (addr_prefix | {16'h0, off_fld}) +
                                     32'(byte_idx - IDX_DATA);
                    awaited_words.push_back(w);
                end
                if (byte_idx < IDX_SAT) byte_idx = byte_idx + 10'd1;
            end
        end
        if (char_cnt < CNT_SAT) char_cnt = char_cnt + 11'd1;
        if (!is_last) return;

        // Line end: the first failing check decides the status.
        len = int'(pos) + 1;
        if (err_flags[0])                                   st = ST_HEADER;
        else if (len % 2 == 0 || len > LINE_LIMIT)          st = ST_SIZE;
        else if (err_flags[1])                              st = ST_CHAR;
        else if (!skip_checksum && line_sum != 8'h00)       st = ST_CHECKSUM;
        else if (byte_idx < HDR_BYTES ||
                 {2'b00, cnt_fld} != byte_idx - HDR_BYTES)  st = ST_SIZE;
        else if (type_fld > REC_LAST)                       st = ST_TYPE;
        else if ((type_fld == REC_EXT_SEG || type_fld == REC_EXT_LIN) &&
                 (cnt_fld != EXT_FORMAT_COUNT || off_fld != 16'h0)) st = ST_FORMAT;
        else                                                st = ST_OK;

        w = '0;
        w.kind = KIND_STATUS;
        w.status = st;
        if (st == ST_OK) begin
            w.accepted_type = type_fld[2:0];
            if (type_fld == REC_DATA) begin
                w.record_start = addr_prefix | {16'h0, off_fld};
                w.section_break = sect_open && next_addr != w.record_start;
                sect_open = 1'b1;
                next_addr = w.record_start + {24'h0, cnt_fld};
            end else if (type_fld == REC_EXT_SEG) begin
                addr_prefix = {12'h0, ext_fld, 4'h0};
            end else if (type_fld == REC_EXT_LIN) begin
                addr_prefix = {ext_fld, 16'h0};
            end
        end
        awaited_words.push_back(w);

        // Clear the per-line state for the next line.
        char_cnt  = '0;
        hi_nib    = '0;
        byte_idx  = '0;
        line_sum  = '0;
        cnt_fld   = '0;
        type_fld  = '0;
        off_fld   = '0;
        ext_fld   = '0;
        err_flags = '0;
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("%s", msg);
    endtask

    // Present one word at the falling edge and hold it until the block takes it.
    // Enter and leave at a falling edge.
    task automatic drive_char(input logic [7:0] c, input logic is_last);
        while (!calm && $urandom_range(0, 99) < 6) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= '{character: c, line_end: is_last};
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        @(negedge i_clk);
        chars_sent++;
    endtask

    task automatic send_line(input logic [7:0] txt[$]);
        foreach (txt[i]) begin
            decode_character(txt[i], i == txt.size() - 1);
            drive_char(txt[i], i == txt.size() - 1);
        end
        lines_sent++;
    endtask

    // Build one record line: mostly well formed, with random content, and now and
    // then broken in one of the ways the status checks look for.
    task automatic random_line();
        logic [7:0]  rec[$];
        logic [7:0]  txt[$];
        logic [7:0]  rtype;
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [15:0] off;
        logic        ext_rec;
        int          n_data;
        int          roll;
        int          flaw;
        int          cut;

        roll = $urandom_range(0, 99);
        if (roll < 55)      rtype = REC_DATA;
        else if (roll < 63) rtype = REC_EOF;
        else if (roll < 73) rtype = REC_EXT_SEG;
        else if (roll < 78) rtype = REC_START_SEG;
        else if (roll < 88) rtype = REC_EXT_LIN;
        else if (roll < 93) rtype = REC_LAST;
        else                rtype = 8'($urandom_range(6, 255));
        ext_rec = (rtype == REC_EXT_SEG || rtype == REC_EXT_LIN);

        if (ext_rec && $urandom_range(0, 99) < 85) begin
            n_data = 2;
            off = 16'h0;
        end else begin
            roll = $urandom_range(0, 99);
            n_data = (roll < 2) ? 255 : (ext_rec ? $urandom_range(0, 4) : $urandom_range(0, 16));
            // Aim at the open section often so both contiguous and broken sections occur;
            // offsets near the top of the 64K window exercise address carry.
            roll = $urandom_range(0, 99);
            if (roll < 50)      off = next_addr[15:0];
            else if (roll < 65) off = 16'hFFF0 | 16'($urandom_range(0, 15));
            else                off = 16'($urandom);
        end

        flaw = $urandom_range(0, 99);
        rec.push_back(8'(n_data));
        // Count field that disagrees with the data length, checksum kept right.
        if (flaw >= 88 && flaw <= 91) rec[0] = rec[0] + 8'($urandom_range(1, 255));
        rec.push_back(off[15:8]);
        rec.push_back(off[7:0]);
        rec.push_back(rtype);
        repeat (n_data) rec.push_back(8'($urandom));
        sum = '0;
        foreach (rec[i]) sum = sum + rec[i];
        b = 8'h00 - sum;
        if (flaw >= 80 && flaw <= 84) b = b + 8'($urandom_range(1, 255));
        rec.push_back(b);

        txt.push_back(COLON);
        foreach (rec[i]) begin
            txt.push_back(hex_char(rec[i][7:4]));
            txt.push_back(hex_char(rec[i][3:0]));
        end

        if (flaw >= 70 && flaw <= 74) begin
            // Missing start code.
            do b = 8'($urandom); while (b == COLON);
            txt[0] = b;
        end else if (flaw >= 75 && flaw <= 79) begin
            // Any byte in place of a digit, hex or not.
            txt[$urandom_range(1, txt.size() - 1)] = 8'($urandom);
        end else if (flaw >= 85 && flaw <= 87) begin
            txt.delete($urandom_range(1, txt.size() - 1));
        end else if (flaw >= 92 && flaw <= 95) begin
            cut = $urandom_range(0, txt.size() - 2);
            txt = txt[0:cut];
        end else if (flaw >= 96) begin
            // Pure noise, sometimes with a start code in front.
            txt.delete();
            cut = $urandom_range(1, 24);
            repeat (cut) txt.push_back(8'($urandom));
            if ($urandom_range(0, 1)) txt[0] = COLON;
        end
        send_line(txt);
    endtask

    task automatic random_phase(input int n_chars);
        int first;
        first = chars_sent;
        while (chars_sent - first < n_chars) random_line();
    endtask

    // Drop valid, wait for every awaited word, then let the pipeline go quiet.
    task automatic settle();
        int waited;
        i_in_valid <= 1'b0;
        waited = 0;
        while (awaited_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (awaited_words.size() != 0) begin
            report_failure($sformatf("%0d expected words never arrived", awaited_words.size()));
            awaited_words.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_skip_checksum(input logic v);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        skip_checksum = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Stall the result side at random, about 6 percent of the time, except in the calm stretch.
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 6);
    end

    // Check each taken result word against the oldest expectation, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_words.size() == 0) begin
                report_failure($sformatf("unexpected word: kind %0d byte %02h addr %08h status %0d",
                    o_out_word.kind, o_out_word.data_byte, o_out_word.byte_address,
                    o_out_word.status));
            end else begin
                want = awaited_words.pop_front();
                if (want.kind == KIND_DATA) data_checked++;
                else begin
                    status_checked++;
                    status_seen[want.status]++;
                end
                if (o_out_word.kind !== want.kind ||
                    o_out_word.data_byte !== want.data_byte ||
                    o_out_word.byte_address !== want.byte_address ||
                    o_out_word.status !== want.status ||
                    o_out_word.accepted_type !== want.accepted_type ||
                    o_out_word.section_break !== want.section_break ||
                    o_out_word.record_start !== want.record_start) begin
                    report_failure($sformatf({"mismatch (expected/actual): kind %0d/%0d ",
                        "byte %02h/%02h addr %08h/%08h status %0d/%0d type %0d/%0d ",
                        "break %0d/%0d start %08h/%08h"},
                        want.kind, o_out_word.kind, want.data_byte, o_out_word.data_byte,
                        want.byte_address, o_out_word.byte_address,
                        want.status, o_out_word.status,
                        want.accepted_type, o_out_word.accepted_type,
                        want.section_break, o_out_word.section_break,
                        want.record_start, o_out_word.record_start));
                end
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        i_out_ready = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed lines with the checksum test active (reset value).
        foreach (directed_rows[i]) begin
            decode_character(directed_rows[i].ch, directed_rows[i].is_last);
            if (directed_rows[i].typed) begin
                // Hold the predictor state, but check against the hand-written status.
                want = '0;
                want.kind = KIND_STATUS;
                want.status = directed_rows[i].st;
                want.accepted_type = directed_rows[i].rt;
                void'(awaited_words.pop_back());
                awaited_words.push_back(want);
            end
            drive_char(directed_rows[i].ch, directed_rows[i].is_last);
        end
        settle();

        random_phase(PHASE_CHARS);

        // Skip the checksum test, with no idling on either side.
        write_skip_checksum(1'b1);
        calm = 1'b1;
        random_phase(PHASE_CHARS);
        calm = 1'b0;

        // Back to checking.
        write_skip_checksum(1'b0);
        random_phase(PHASE_CHARS);
        settle();

        $display("summary: %0d lines, %0d characters, %0d data bytes, %0d status words checked",
            lines_sent, chars_sent, data_checked, status_checked);
        $display("summary: status ok/hdr/size/char/csum/type/fmt = %0d/%0d/%0d/%0d/%0d/%0d/%0d",
            status_seen[ST_OK], status_seen[ST_HEADER], status_seen[ST_SIZE],
            status_seen[ST_CHAR], status_seen[ST_CHECKSUM], status_seen[ST_TYPE],
            status_seen[ST_FORMAT]);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[intel_hex_record_decoder.f]
hw/rtl/ihd_pkg.sv
hw/rtl/ihd_line.sv
hw/rtl/ihd_record.sv
hw/rtl/intel_hex_record_decoder.sv
bench/intel_hex_record_decoder_tb.sv
